FILE: rtl/bres_pkg.sv
// Shared types and constants for the line plotter with page-organized frame store.
// Used by bres_step, bres_fb, the top level, the pixel checker and the test top.
package bres_pkg;

    localparam int X_W    = 7;
    localparam int Y_W    = 6;
    localparam int PAGE_W = 3;
    localparam int BYTE_W = 8;
    localparam int ERR_W  = 10;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    localparam logic [BYTE_W-1:0] PIX_BIT = 8'h01;

    typedef struct packed {
        logic           valid;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic           last;
    } pix_t;

endpackage

FILE: rtl/bres_step.sv
// Bresenham stepper: holds the line state, latches endpoints on a load beat
// and emits one pixel per accepted advance beat while a line is active. Depends on bres_pkg.
module bres_step (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     accept,
    input  logic                     action,
    input  logic [bres_pkg::X_W-1:0] start_x,
    input  logic [bres_pkg::Y_W-1:0] start_y,
    input  logic [bres_pkg::X_W-1:0] end_x,
    input  logic [bres_pkg::Y_W-1:0] end_y,
    output bres_pkg::pix_t           pix
);

    logic [bres_pkg::X_W-1:0]   cur_x_reg, cur_x_next;
    logic [bres_pkg::Y_W-1:0]   cur_y_reg, cur_y_next;
    logic [bres_pkg::X_W-1:0]   target_x_reg, target_x_next;
    logic [bres_pkg::Y_W-1:0]   target_y_reg, target_y_next;
    logic [bres_pkg::ERR_W-1:0] error_reg, error_next;
    logic                       step_left_reg, step_left_next;
    logic                       step_up_reg, step_up_next;
    logic [bres_pkg::X_W-1:0]   run_x_reg, run_x_next;
    logic [bres_pkg::Y_W-1:0]   run_y_reg, run_y_next;
    logic                       x_major_reg, x_major_next;
    logic                       active_reg, active_next;

    logic                       ld_left, ld_up, ld_xmaj;
    logic [bres_pkg::X_W-1:0]   ld_rx;
    logic [bres_pkg::Y_W-1:0]   ld_ry;
    logic [bres_pkg::ERR_W-1:0] ld_two_rx, ld_two_ry;
    logic [bres_pkg::ERR_W-1:0] two_major, two_minor;
    logic                       done, minor_step;
    logic [bres_pkg::X_W-1:0]   x_step;
    logic [bres_pkg::Y_W-1:0]   y_step;

    always_comb begin
        ld_left   = end_x < start_x;
        ld_up     = end_y < start_y;
        ld_rx     = ld_left ? start_x - end_x : end_x - start_x;
        ld_ry     = ld_up ? start_y - end_y : end_y - start_y;
        ld_xmaj   = ld_rx >= {1'b0, ld_ry};
        ld_two_rx = {2'b00, ld_rx, 1'b0};
        ld_two_ry = {3'b000, ld_ry, 1'b0};

        two_major = x_major_reg ? {2'b00, run_x_reg, 1'b0} : {3'b000, run_y_reg, 1'b0};
        two_minor = x_major_reg ? {3'b000, run_y_reg, 1'b0} : {2'b00, run_x_reg, 1'b0};
        done       = x_major_reg ? (cur_x_reg == target_x_reg) : (cur_y_reg == target_y_reg);
        minor_step = !error_reg[bres_pkg::ERR_W-1];
        x_step     = step_left_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
        y_step     = step_up_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;

        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        target_x_next  = target_x_reg;
        target_y_next  = target_y_reg;
        error_next     = error_reg;
        step_left_next = step_left_reg;
        step_up_next   = step_up_reg;
        run_x_next     = run_x_reg;
        run_y_next     = run_y_reg;
        x_major_next   = x_major_reg;
        active_next    = active_reg;
        pix            = '0;

        if (accept && action == bres_pkg::ACT_LOAD) begin
            cur_x_next     = start_x;
            cur_y_next     = start_y;
            target_x_next  = end_x;
            target_y_next  = end_y;
            step_left_next = ld_left;
            step_up_next   = ld_up;
            run_x_next     = ld_rx;
            run_y_next     = ld_ry;
            x_major_next   = ld_xmaj;
            error_next     = ld_xmaj ? ld_two_ry - {3'b000, ld_rx}
                                     : ld_two_rx - {4'b0000, ld_ry};
            active_next    = 1'b1;
        end else if (accept && action == bres_pkg::ACT_ADVANCE && active_reg) begin
            pix.valid = 1'b1;
            pix.x     = cur_x_reg;
            pix.y     = cur_y_reg;
            pix.last  = done;
            if (done) begin
                active_next = 1'b0;
            end else begin
                error_next = minor_step ? error_reg + two_minor - two_major
                                        : error_reg + two_minor;
                if (x_major_reg) begin
                    cur_x_next = x_step;
                    if (minor_step) begin
                        cur_y_next = y_step;
                    end
                end else begin
                    cur_y_next = y_step;
                    if (minor_step) begin
                        cur_x_next = x_step;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            target_x_reg  <= '0;
            target_y_reg  <= '0;
            error_reg     <= '0;
            step_left_reg <= 1'b0;
            step_up_reg   <= 1'b0;
            run_x_reg     <= '0;
            run_y_reg     <= '0;
            x_major_reg   <= 1'b0;
            active_reg    <= 1'b0;
        end else begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            target_x_reg  <= target_x_next;
            target_y_reg  <= target_y_next;
            error_reg     <= error_next;
            step_left_reg <= step_left_next;
            step_up_reg   <= step_up_next;
            run_x_reg     <= run_x_next;
            run_y_reg     <= run_y_next;
            x_major_reg   <= x_major_next;
            active_reg    <= active_next;
        end
    end

endmodule

FILE: rtl/bres_fb.sv
// Frame store with read-modify-write stage, read-after-write bypass, clearing
// pass after reset and the result register. Depends on bres_pkg.
module bres_fb #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bres_pkg::pix_t                pix,
    input  logic                          out_ready,
    output logic                          in_ready,
    output logic                          out_valid,
    output logic [bres_pkg::X_W-1:0]      out_column,
    output logic [bres_pkg::PAGE_W-1:0]   out_page,
    output logic [bres_pkg::BYTE_W-1:0]   out_byte,
    output logic                          out_last
);

    localparam int DEPTH  = COLUMNS * PAGES;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [bres_pkg::BYTE_W-1:0] mem [DEPTH];

    logic                        clr_active_reg, clr_active_next;
    logic [ADDR_W-1:0]           clr_addr_reg, clr_addr_next;

    logic                        s1_valid_reg, s1_valid_next;
    logic [ADDR_W-1:0]           s1_addr_reg;
    logic                        s1_inb_reg;
    logic [bres_pkg::BYTE_W-1:0] s1_bit_reg;
    logic [bres_pkg::X_W-1:0]    s1_col_reg;
    logic [bres_pkg::PAGE_W-1:0] s1_page_reg;
    logic                        s1_last_reg;
    logic [bres_pkg::BYTE_W-1:0] rd_reg;
    logic                        hit_reg, hit_next;
    logic [bres_pkg::BYTE_W-1:0] byp_reg;

    logic                        m_valid_reg, m_valid_next;
    logic [bres_pkg::X_W-1:0]    m_col_reg;
    logic [bres_pkg::PAGE_W-1:0] m_page_reg;
    logic [bres_pkg::BYTE_W-1:0] m_byte_reg;
    logic                        m_last_reg;

    logic [bres_pkg::PAGE_W-1:0] in_page;
    logic                        in_inb;
    logic [ADDR_W-1:0]           in_addr;
    logic                        take;
    logic                        s1_adv;
    logic [bres_pkg::BYTE_W-1:0] new_byte;
    logic                        we;
    logic [ADDR_W-1:0]           wa;
    logic [bres_pkg::BYTE_W-1:0] wd;

    always_comb begin
        in_page  = pix.y[bres_pkg::Y_W-1:3];
        in_inb   = ({2'b00, pix.x} < 9'(COLUMNS)) && ({2'b00, in_page} < 5'(PAGES));
        in_addr  = in_inb ? ADDR_W'(int'(pix.x) + int'(in_page) * COLUMNS) : '0;
        s1_adv   = s1_valid_reg && (!m_valid_reg || out_ready);
        in_ready = !clr_active_reg && (!s1_valid_reg || s1_adv);
        take     = pix.valid;
        new_byte = s1_inb_reg ? ((hit_reg ? byp_reg : rd_reg) | s1_bit_reg) : s1_bit_reg;
        hit_next = s1_adv && s1_inb_reg && in_inb && (s1_addr_reg == in_addr);

        s1_valid_next = take || (s1_valid_reg && !s1_adv);
        m_valid_next  = s1_adv || (m_valid_reg && !out_ready);

        clr_active_next = clr_active_reg && (clr_addr_reg != ADDR_W'(DEPTH - 1));
        clr_addr_next   = clr_active_reg ? clr_addr_reg + 1'b1 : clr_addr_reg;

        if (clr_active_reg) begin
            we = 1'b1;
            wa = clr_addr_reg;
            wd = '0;
        end else begin
            we = s1_adv && s1_inb_reg;
            wa = s1_addr_reg;
            wd = new_byte;
        end

        out_valid  = m_valid_reg;
        out_column = m_col_reg;
        out_page   = m_page_reg;
        out_byte   = m_byte_reg;
        out_last   = m_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (take) begin
            rd_reg      <= mem[in_addr];
            hit_reg     <= hit_next;
            s1_addr_reg <= in_addr;
            s1_inb_reg  <= in_inb;
            s1_bit_reg  <= bres_pkg::PIX_BIT << pix.y[2:0];
            s1_col_reg  <= pix.x;
            s1_page_reg <= in_page;
            s1_last_reg <= pix.last;
        end
        if (s1_adv) begin
            byp_reg    <= new_byte;
            m_col_reg  <= s1_col_reg;
            m_page_reg <= s1_page_reg;
            m_byte_reg <= new_byte;
            m_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            s1_valid_reg   <= s1_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

endmodule

FILE: rtl/bresenham_line_to_page_framebuffer_top.sv
// Top level of the line plotter: stepper plus page-organized frame store.
// Depends on bres_pkg, bres_step and bres_fb.
//
//  Side    | Beat meaning                     | tuser / tlast
//  s_      | load endpoints or advance pixel  | tuser = action
//  m_      | updated frame store byte         | tlast = last pixel of the line
//
// The block accepts one beat per cycle while s_tready is high; a plotted pixel passes
// the frame store read stage and then the result register on its way to m_.
// After reset a clearing pass writes zeros over all COLUMNS * PAGES bytes (1024 by
// default), one a cycle, and s_tready stays low until it ends.
// A stalled m_ side holds one beat in the result register and one in the read
// stage; outside the clearing pass s_tready drops only when both are full.
module bresenham_line_to_page_framebuffer_top #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // start_x[6:0], start_y[12:7], end_x[19:13], end_y[25:20]
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // column[6:0], page[9:7], data_byte[17:10]
    output logic        m_tlast
);

    logic                        accept;
    bres_pkg::pix_t              pix;
    logic [bres_pkg::X_W-1:0]    column;
    logic [bres_pkg::PAGE_W-1:0] page;
    logic [bres_pkg::BYTE_W-1:0] data_byte;

    assign accept  = s_tvalid && s_tready;
    assign m_tdata = {6'b000000, data_byte, page, column};

    bres_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .action  (s_tuser),
        .start_x (s_tdata[6:0]),
        .start_y (s_tdata[12:7]),
        .end_x   (s_tdata[19:13]),
        .end_y   (s_tdata[25:20]),
        .pix     (pix)
    );

    bres_fb #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_fb (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pix        (pix),
        .out_ready  (m_tready),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_column (column),
        .out_page   (page),
        .out_byte   (data_byte),
        .out_last   (m_tlast)
    );

endmodule

FILE: rtl/bres_chk.sv
// Port-level checker for the line plotter top level, bound to it below.
// Depends only on the top level's ports.
module bres_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // The clearing pass keeps the input closed right after reset.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("s_tready high during the clearing pass");

    // A result beat that waits must not change.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // A fresh result comes from an advance beat taken earlier, through the read stage and the result register.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser, 2))
        else $error("result appeared without a matching advance beat");

endmodule

bind bresenham_line_to_page_framebuffer_top bres_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: tb/sv/bres_pixel_checker.sv
`timescale 1ns / 100ps
// Pixel checker for the line plotter: watches both stream channels, predicts every
// plotted frame store byte and compares it with the m_ beats. Depends on bres_pkg.
module bres_pixel_checker #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [bres_pkg::X_W-1:0]    column;
        logic [bres_pkg::PAGE_W-1:0] page;
        logic [bres_pkg::BYTE_W-1:0] data_byte;
        logic                        last;
    } pixel_beat_t;

    pixel_beat_t                       expected_pixels [$];
    logic [bres_pkg::BYTE_W-1:0]       frame_bytes [COLUMNS*PAGES];
    logic [bres_pkg::X_W-1:0]          cur_x, target_x, run_x;
    logic [bres_pkg::Y_W-1:0]          cur_y, target_y, run_y;
    logic signed [bres_pkg::ERR_W-1:0] err_acc;
    logic                              step_left, step_up, x_major, line_active;
    int                                shown;

    task automatic plot_beat(input logic act, input logic [31:0] data);
        logic [bres_pkg::X_W-1:0]    sx, ex;
        logic [bres_pkg::Y_W-1:0]    sy, ey;
        logic [bres_pkg::PAGE_W-1:0] pg;
        logic [bres_pkg::BYTE_W-1:0] pix, byte_now;
        logic                        done, minor_step;
        pixel_beat_t                 beat;
        int                          major, minor, e;
        if (act == bres_pkg::ACT_LOAD) begin
            sx = data[bres_pkg::X_W-1:0];
            sy = data[bres_pkg::X_W +: bres_pkg::Y_W];
            ex = data[bres_pkg::X_W+bres_pkg::Y_W +: bres_pkg::X_W];
            ey = data[2*bres_pkg::X_W+bres_pkg::Y_W +: bres_pkg::Y_W];
            cur_x = sx;
            cur_y = sy;
            target_x = ex;
            target_y = ey;
            step_left = ex < sx;
            step_up = ey < sy;
            run_x = step_left ? sx - ex : ex - sx;
            run_y = step_up ? sy - ey : ey - sy;
            x_major = int'(run_x) >= int'(run_y);
            e = x_major ? 2 * int'(run_y) - int'(run_x) : 2 * int'(run_x) - int'(run_y);
            err_acc = e[bres_pkg::ERR_W-1:0];
            line_active = 1'b1;
        end else if (line_active) begin
            pix = bres_pkg::PIX_BIT << cur_y[2:0];
            pg = cur_y[bres_pkg::Y_W-1:3];
            if (int'(cur_x) < COLUMNS && int'(pg) < PAGES) begin
                frame_bytes[int'(cur_x) + COLUMNS * int'(pg)] |= pix;
                byte_now = frame_bytes[int'(cur_x) + COLUMNS * int'(pg)];
            end else begin
                byte_now = pix;
            end
            done = x_major ? (cur_x == target_x) : (cur_y == target_y);
            beat.column = cur_x;
            beat.page = pg;
            beat.data_byte = byte_now;
            beat.last = done;
            expected_pixels.push_back(beat);
            if (done) begin
                line_active = 1'b0;
            end else begin
                major = x_major ? int'(run_x) : int'(run_y);
                minor = x_major ? int'(run_y) : int'(run_x);
                minor_step = !err_acc[bres_pkg::ERR_W-1];
                e = int'(err_acc) + 2 * minor - (minor_step ? 2 * major : 0);
                err_acc = e[bres_pkg::ERR_W-1:0];
                if (x_major || minor_step) begin
                    cur_x = step_left ? cur_x - 1'b1 : cur_x + 1'b1;
                end
                if (!x_major || minor_step) begin
                    cur_y = step_up ? cur_y - 1'b1 : cur_y + 1'b1;
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        pixel_beat_t got, want;
        if (!aresetn) begin
            foreach (frame_bytes[i]) frame_bytes[i] = '0;
            cur_x = '0;
            cur_y = '0;
            target_x = '0;
            target_y = '0;
            run_x = '0;
            run_y = '0;
            err_acc = '0;
            step_left = 1'b0;
            step_up = 1'b0;
            x_major = 1'b0;
            line_active = 1'b0;
            expected_pixels.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.column = m_tdata[bres_pkg::X_W-1:0];
                got.page = m_tdata[bres_pkg::X_W +: bres_pkg::PAGE_W];
                got.data_byte = m_tdata[bres_pkg::X_W+bres_pkg::PAGE_W +: bres_pkg::BYTE_W];
                got.last = m_tlast;
                if (expected_pixels.size() == 0) begin
                    errors++;
                    if (shown < 10) begin
                        shown++;
                        $display("%0t: unexpected m_ beat col %0d page %0d byte %02h last %0b",
                            $realtime, got.column, got.page, got.data_byte, got.last);
                    end
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.column !== want.column || got.page !== want.page ||
                        got.data_byte !== want.data_byte || got.last !== want.last) begin
                        errors++;
                        if (shown < 10) begin
                            shown++;
                            $display("%0t: m_ beat mismatch, expected col %0d page %0d",
                                $realtime, want.column, want.page);
                            $display("    expected byte %02h last %0b",
                                want.data_byte, want.last);
                            $display("    got col %0d page %0d byte %02h last %0b",
                                got.column, got.page, got.data_byte, got.last);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                plot_beat(s_tuser, s_tdata);
            end
        end
        pending = expected_pixels.size();
    end

endmodule

FILE: tb/sv/bresenham_line_to_page_framebuffer_top_test.sv
`timescale 1ns / 100ps
// Test top for the line plotter: drives load and advance beats with bursty timing and
// a stalling receiver, and gives the verdict. Depends on bres_pkg, the top level and bres_pixel_checker.
module bresenham_line_to_page_framebuffer_top_test;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    int          errors;
    int          pending;
    int          n_items = 0;
    int          burst_left = 0;

    bresenham_line_to_page_framebuffer_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    bres_pixel_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .errors(errors), .pending(pending)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic offer(input logic act, input logic [31:0] data);
        @(negedge aclk);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic load_line(input int sx, input int sy, input int ex, input int ey);
        logic [bres_pkg::X_W-1:0] sx_v, ex_v;
        logic [bres_pkg::Y_W-1:0] sy_v, ey_v;
        sx_v = sx[bres_pkg::X_W-1:0];
        sy_v = sy[bres_pkg::Y_W-1:0];
        ex_v = ex[bres_pkg::X_W-1:0];
        ey_v = ey[bres_pkg::Y_W-1:0];
        offer(bres_pkg::ACT_LOAD, {6'd0, ey_v, ex_v, sy_v, sx_v});
        n_items++;
    endtask

    task automatic advance(input int count);
        repeat (count) begin
            offer(bres_pkg::ACT_ADVANCE, $urandom);
            n_items++;
        end
    endtask

    function automatic int clamp(input int v, input int hi);
        return (v < 0) ? 0 : (v > hi) ? hi : v;
    endfunction

    initial begin : sink
        int cyc;
        int mode;
        bit held_off;
        cyc = 0;
        mode = 0;
        held_off = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            cyc++;
            if (!held_off && n_items >= 150) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
            end else begin
                if (cyc % 64 == 0) mode = $urandom_range(0, 3);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= cyc[1];
                endcase
            end
        end
    end

    initial begin : source
        int sx, sy, ex, ey, dx, dy, npix, nadv, k, line_no;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // An advance with no line active gives nothing.
        advance(1);
        load_line(5, 5, 5, 5);
        advance(1);
        advance(1);
        // Loads that replace a line still in progress.
        load_line(127, 63, 0, 0);
        advance(3);
        load_line(0, 0, 127, 63);
        advance(2);
        load_line(10, 20, 14, 20);
        advance(5);
        load_line(60, 40, 58, 46);
        advance(7);

        line_no = 0;
        while (n_items < 1050) begin
            sx = $urandom_range(0, 127);
            sy = $urandom_range(0, 63);
            if (line_no == 0) begin
                sx = 0; sy = 0; ex = 127; ey = 63;
            end else if (line_no == 1) begin
                sx = 127; sy = 0; ex = 0; ey = 63;
            end else if ($urandom_range(0, 99) < 70) begin
                ex = clamp(sx + $urandom_range(0, 16) - 8, 127);
                ey = clamp(sy + $urandom_range(0, 16) - 8, 63);
            end else begin
                ex = $urandom_range(0, 127);
                ey = $urandom_range(0, 63);
            end
            line_no++;
            dx = (ex > sx) ? ex - sx : sx - ex;
            dy = (ey > sy) ? ey - sy : sy - ey;
            npix = ((dx > dy) ? dx : dy) + 1;
            k = $urandom_range(0, 9);
            nadv = (k == 0) ? $urandom_range(0, npix - 1) : npix;
            load_line(sx, sy, ex, ey);
            advance(nadv);
            if (k == 1) begin
                advance($urandom_range(1, 2));
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bres_pkg.sv
rtl/bres_step.sv
rtl/bres_fb.sv
rtl/bresenham_line_to_page_framebuffer_top.sv
rtl/bres_chk.sv
tb/sv/bres_pixel_checker.sv
tb/sv/bresenham_line_to_page_framebuffer_top_test.sv
